// ----- rtl/igp_pkg.sv -----
// Package for the ideal gas pressure cell unit: shared types, constants and
// IEEE single precision arithmetic functions (multiply, add, compare).
// Depends on nothing.
package igp_pkg;

   typedef logic [31:0] fp_type;

   localparam int unsigned NumLanes = 5;
   localparam int unsigned NumStages = 10;

   localparam int unsigned LaneDens = 0;
   localparam int unsigned LaneEnergy = 1;
   localparam int unsigned LaneVelX = 2;
   localparam int unsigned LaneVelY = 3;
   localparam int unsigned LaneVelZ = 4;

   localparam logic [2:0] RegInterpWeight = 3'd0;
   localparam logic [2:0] RegGamma = 3'd1;
   localparam logic [2:0] RegPressureFloor = 3'd2;
   localparam logic [2:0] RegKineticOn = 3'd3;
   localparam logic [2:0] RegEosIsothermal = 3'd4;
   localparam logic [2:0] RegSoundSpeed = 3'd5;
   localparam logic [2:0] RegGridRank = 3'd6;

   localparam fp_type FpOne = 32'h3F80_0000;
   localparam fp_type FpHalf = 32'h3F00_0000;
   localparam fp_type FpZero = 32'h0000_0000;
   localparam fp_type FpGammaReset = 32'h3FD5_5555;
   localparam fp_type FpDefaultNan = 32'hFFC0_0000;
   localparam fp_type FpQuietBit = 32'h0040_0000;

   typedef struct packed {
      fp_type     interp_weight;
      fp_type     weight_old;
      fp_type     gamma_m1;
      fp_type     pressure_floor;
      fp_type     sound_speed_sq;
      fp_type     kinetic_k;
      logic       eos_isothermal;
      logic [1:0] grid_rank;
   } csr_type;

   function automatic logic fp_is_nan(fp_type a);
      return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
   endfunction

   function automatic logic fp_is_inf(fp_type a);
      return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
   endfunction

   function automatic fp_type fp_mul(fp_type a, fp_type b);
      logic              s;
      logic [7:0]        ea;
      logic [7:0]        eb;
      logic [23:0]       ma;
      logic [23:0]       mb;
      logic [47:0]       p;
      logic [5:0]        lz;
      logic              found;
      logic signed [10:0] be;
      logic [5:0]        sh;
      logic              st;
      logic              inc;
      logic [24:0]       r;
      fp_type            res;
      s = a[31] ^ b[31];
      ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
      eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
      ma = {a[30:23] != 8'd0, a[22:0]};
      mb = {b[30:23] != 8'd0, b[22:0]};
      p = '0;
      lz = '0;
      found = 1'b0;
      be = '0;
      sh = '0;
      st = 1'b0;
      inc = 1'b0;
      r = '0;
      if (fp_is_nan(a)) begin
         res = a | FpQuietBit;
      end else if (fp_is_nan(b)) begin
         res = b | FpQuietBit;
      end else if ((fp_is_inf(a) && b[30:0] == 31'd0) ||
                   (fp_is_inf(b) && a[30:0] == 31'd0)) begin
         res = FpDefaultNan;
      end else if (fp_is_inf(a) || fp_is_inf(b)) begin
         res = {s, 8'hFF, 23'd0};
      end else if (a[30:0] == 31'd0 || b[30:0] == 31'd0) begin
         res = {s, 31'd0};
      end else begin
         p = ma * mb;
         for (int i = 47; i >= 0; i--) begin
            if (!found) begin
               if (p[i]) found = 1'b1;
               else lz = lz + 6'd1;
            end
         end
         p = p << lz;
         be = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd126
              - $signed({5'b00000, lz});
         if (be < 11'sd1) begin
            if (be < -11'sd46) begin
               st = |p;
               p = '0;
            end else begin
               sh = 6'(11'sd1 - be);
               st = |(p & ((48'd1 << sh) - 48'd1));
               p = p >> sh;
            end
            be = 11'sd1;
         end
         inc = p[23] & (st | (|p[22:0]) | p[24]);
         r = {1'b0, p[47:24]} + {24'd0, inc};
         if (r[24]) begin
            r = r >> 1;
            be = be + 11'sd1;
         end
         if (be >= 11'sd255) res = {s, 8'hFF, 23'd0};
         else res = {s, r[23] ? be[7:0] : 8'd0, r[22:0]};
      end
      return res;
   endfunction

   function automatic fp_type fp_add(fp_type a, fp_type b, logic sub);
      fp_type            bn;
      fp_type            x;
      fp_type            y;
      logic              eff_sub;
      logic [7:0]        ex;
      logic [7:0]        ey;
      logic [7:0]        d;
      logic [27:0]       ax;
      logic [27:0]       ay0;
      logic [27:0]       ay;
      logic [27:0]       sum;
      logic [4:0]        lz;
      logic              found;
      logic [9:0]        lim;
      logic signed [9:0] e;
      logic              inc;
      logic [24:0]       r;
      fp_type            res;
      bn = {b[31] ^ sub, b[30:0]};
      x = '0;
      y = '0;
      eff_sub = 1'b0;
      ex = '0;
      ey = '0;
      d = '0;
      ax = '0;
      ay0 = '0;
      ay = '0;
      sum = '0;
      lz = '0;
      found = 1'b0;
      lim = '0;
      e = '0;
      inc = 1'b0;
      r = '0;
      if (fp_is_nan(a)) begin
         res = a | FpQuietBit;
      end else if (fp_is_nan(b)) begin
         res = b | FpQuietBit;
      end else if (fp_is_inf(a) && fp_is_inf(bn) && (a[31] != bn[31])) begin
         res = FpDefaultNan;
      end else if (fp_is_inf(a)) begin
         res = a;
      end else if (fp_is_inf(bn)) begin
         res = bn;
      end else begin
         if (a[30:0] >= bn[30:0]) begin
            x = a;
            y = bn;
         end else begin
            x = bn;
            y = a;
         end
         eff_sub = x[31] ^ y[31];
         ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
         ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
         d = ex - ey;
         ax = {1'b0, x[30:23] != 8'd0, x[22:0], 3'b000};
         ay0 = {1'b0, y[30:23] != 8'd0, y[22:0], 3'b000};
         if (d >= 8'd27) begin
            ay = {27'd0, |ay0};
         end else begin
            ay = ay0 >> d;
            ay[0] = ay[0] | (|(ay0 & ((28'd1 << d) - 28'd1)));
         end
         sum = eff_sub ? (ax - ay) : (ax + ay);
         if (sum == 28'd0) begin
            res = {eff_sub ? 1'b0 : x[31], 31'd0};
         end else begin
            e = $signed({2'b00, ex});
            if (sum[27]) begin
               sum = {1'b0, sum[27:2], sum[1] | sum[0]};
               e = e + 10'sd1;
            end else begin
               for (int i = 26; i >= 0; i--) begin
                  if (!found) begin
                     if (sum[i]) found = 1'b1;
                     else lz = lz + 5'd1;
                  end
               end
               lim = 10'(e - 10'sd1);
               if ({5'd0, lz} > lim) lz = lim[4:0];
               sum = sum << lz;
               e = e - $signed({5'd0, lz});
            end
            inc = sum[2] & (sum[1] | sum[0] | sum[3]);
            r = {1'b0, sum[26:3]} + {24'd0, inc};
            if (r[24]) begin
               r = r >> 1;
               e = e + 10'sd1;
            end
            if (e >= 10'sd255) res = {x[31], 8'hFF, 23'd0};
            else res = {x[31], r[23] ? e[7:0] : 8'd0, r[22:0]};
         end
      end
      return res;
   endfunction

   function automatic logic fp_lt(fp_type a, fp_type b);
      logic res;
      if (fp_is_nan(a) || fp_is_nan(b)) res = 1'b0;
      else if (a[30:0] == 31'd0 && b[30:0] == 31'd0) res = 1'b0;
      else if (a[31] != b[31]) res = a[31];
      else if (!a[31]) res = a[30:0] < b[30:0];
      else res = a[30:0] > b[30:0];
      return res;
   endfunction

endpackage

// ----- rtl/ideal_gas_pressure_cell_unit.sv -----
// Top level of the ideal gas pressure cell unit: configuration registers and
// the ten stage pressure datapath. Uses igp_pkg, igp_csr and igp_pipe.
//
//   channel   direction  handshake              carries
//   req_      in         req_valid, req_stall   ten IEEE single fields, last_cell
//   rsp_      out        rsp_valid, rsp_stall   pressure_out, floored, last_cell_out
//   csr_      in         csr_valid, csr_ready   csr_index, csr_data
//
// Requests pass through the floating point stage chain to their result; one
// request can be accepted each cycle while no result is stalled.
// A stalled result holds the whole pipeline, so req_stall follows rsp_stall
// while a result is waiting. Reset clears the valid bits and loads the
// register defaults; payload registers are not reset.
module ideal_gas_pressure_cell_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_dens_new,
   input  logic [31:0] req_dens_old,
   input  logic [31:0] req_energy_new,
   input  logic [31:0] req_energy_old,
   input  logic [31:0] req_vel_x_new,
   input  logic [31:0] req_vel_x_old,
   input  logic [31:0] req_vel_y_new,
   input  logic [31:0] req_vel_y_old,
   input  logic [31:0] req_vel_z_new,
   input  logic [31:0] req_vel_z_old,
   input  logic        req_last_cell,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_pressure_out,
   output logic        rsp_floored,
   output logic        rsp_last_cell_out,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   import igp_pkg::*;

   csr_type cfg;
   fp_type  lane_new [NumLanes];
   fp_type  lane_old [NumLanes];
   logic    advance;

   assign advance = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   always_comb begin
      lane_new[LaneDens] = req_dens_new;
      lane_old[LaneDens] = req_dens_old;
      lane_new[LaneEnergy] = req_energy_new;
      lane_old[LaneEnergy] = req_energy_old;
      lane_new[LaneVelX] = req_vel_x_new;
      lane_old[LaneVelX] = req_vel_x_old;
      lane_new[LaneVelY] = req_vel_y_new;
      lane_old[LaneVelY] = req_vel_y_old;
      lane_new[LaneVelZ] = req_vel_z_new;
      lane_old[LaneVelZ] = req_vel_z_old;
   end

   igp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   igp_pipe u_pipe (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .advance      (advance),
      .in_valid     (req_valid),
      .in_new       (lane_new),
      .in_old       (lane_old),
      .in_last      (req_last_cell),
      .out_valid    (rsp_valid),
      .out_pressure (rsp_pressure_out),
      .out_floored  (rsp_floored),
      .out_last     (rsp_last_cell_out)
   );

endmodule

// ----- rtl/igp_csr.sv -----
// Configuration registers of the ideal gas pressure cell unit and the
// constants derived from them (1-w, gamma-1, c squared). Uses igp_pkg.
module igp_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_data,
   output igp_pkg::csr_type  cfg
);
   import igp_pkg::*;

   fp_type     interp_weight_ff;
   fp_type     gamma_ff;
   fp_type     pressure_floor_ff;
   logic       kinetic_on_ff;
   logic       eos_isothermal_ff;
   fp_type     sound_speed_ff;
   logic [1:0] grid_rank_ff;
   fp_type     weight_old_ff;
   fp_type     weight_old_in;
   fp_type     gamma_m1_ff;
   fp_type     gamma_m1_in;
   fp_type     sound_speed_sq_ff;
   fp_type     sound_speed_sq_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         interp_weight_ff <= FpOne;
         gamma_ff <= FpGammaReset;
         pressure_floor_ff <= FpZero;
         kinetic_on_ff <= 1'b1;
         eos_isothermal_ff <= 1'b0;
         sound_speed_ff <= FpZero;
         grid_rank_ff <= 2'd3;
      end else if (csr_valid) begin
         unique case (csr_index)
            RegInterpWeight: interp_weight_ff <= csr_data;
            RegGamma: gamma_ff <= csr_data;
            RegPressureFloor: pressure_floor_ff <= csr_data;
            RegKineticOn: kinetic_on_ff <= csr_data[0];
            RegEosIsothermal: eos_isothermal_ff <= csr_data[0];
            RegSoundSpeed: sound_speed_ff <= csr_data;
            RegGridRank: grid_rank_ff <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      weight_old_in = fp_add(FpOne, interp_weight_ff, 1'b1);
      gamma_m1_in = fp_add(gamma_ff, FpOne, 1'b1);
      sound_speed_sq_in = fp_mul(sound_speed_ff, sound_speed_ff);
   end

   always_ff @(posedge clock) begin
      weight_old_ff <= weight_old_in;
      gamma_m1_ff <= gamma_m1_in;
      sound_speed_sq_ff <= sound_speed_sq_in;
   end

   always_comb begin
      cfg.interp_weight = interp_weight_ff;
      cfg.weight_old = weight_old_ff;
      cfg.gamma_m1 = gamma_m1_ff;
      cfg.pressure_floor = pressure_floor_ff;
      cfg.sound_speed_sq = sound_speed_sq_ff;
      cfg.kinetic_k = kinetic_on_ff ? FpHalf : FpZero;
      cfg.eos_isothermal = eos_isothermal_ff;
      cfg.grid_rank = grid_rank_ff;
   end

endmodule

// ----- rtl/igp_pipe.sv -----
// Ten stage floating point datapath: blend, squares, sums, gas
// energy, pressure, floor (not in isothermal mode). Uses igp_pkg.
module igp_pipe (
   input  logic             clock,
   input  logic             reset,
   input  igp_pkg::csr_type cfg,
   input  logic             advance,
   input  logic             in_valid,
   input  igp_pkg::fp_type  in_new [igp_pkg::NumLanes],
   input  igp_pkg::fp_type  in_old [igp_pkg::NumLanes],
   input  logic             in_last,
   output logic             out_valid,
   output igp_pkg::fp_type  out_pressure,
   output logic             out_floored,
   output logic             out_last
);
   import igp_pkg::*;

   logic   valid_ff [NumStages];
   logic   last_ff [NumStages];
   fp_type new0_ff [NumLanes];
   fp_type old0_ff [NumLanes];
   fp_type a1_ff [NumLanes];
   fp_type a1_in [NumLanes];
   fp_type b1_ff [NumLanes];
   fp_type b1_in [NumLanes];
   fp_type new1_ff [NumLanes];
   fp_type blend2_ff [NumLanes];
   fp_type blend2_in [NumLanes];
   fp_type sq3_ff [3];
   fp_type sq3_in [3];
   fp_type rg3_ff, rg3_in, e3_ff;
   fp_type s4_ff, s4_in, sq4_ff, rg4_ff, e4_ff;
   fp_type s5_ff, s5_in, rg5_ff, e5_ff;
   fp_type kin6_ff, kin6_in, rg6_ff, e6_ff;
   fp_type gas7_ff, gas7_in, rg7_ff;
   fp_type p8_ff, p8_in, rg8_ff;
   fp_type pressure9_ff, pressure9_in;
   logic   floored9_ff, floored9_in;
   logic   weight_one;
   logic   use_y;
   logic   use_z;

   assign weight_one = (cfg.interp_weight == FpOne);
   assign use_y = (cfg.grid_rank > 2'd1);
   assign use_z = (cfg.grid_rank > 2'd2);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumStages; i++) valid_ff[i] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i < NumStages; i++) valid_ff[i] <= valid_ff[i-1];
      end
   end

   always_comb begin
      for (int i = 0; i < NumLanes; i++) begin
         a1_in[i] = fp_mul(cfg.interp_weight, new0_ff[i]);
         b1_in[i] = fp_mul(cfg.weight_old, old0_ff[i]);
      end
      for (int i = 0; i < NumLanes; i++) begin
         blend2_in[i] = weight_one ? new1_ff[i] : fp_add(a1_ff[i], b1_ff[i], 1'b0);
      end
      if (!use_y) blend2_in[LaneVelY] = FpZero;
      if (!use_z) blend2_in[LaneVelZ] = FpZero;
      for (int i = 0; i < 3; i++) begin
         sq3_in[i] = fp_mul(blend2_ff[LaneVelX + i], blend2_ff[LaneVelX + i]);
      end
      rg3_in = fp_mul(cfg.eos_isothermal ? cfg.sound_speed_sq : cfg.gamma_m1,
                      blend2_ff[LaneDens]);
      s4_in = fp_add(sq3_ff[0], sq3_ff[1], 1'b0);
      s5_in = fp_add(s4_ff, sq4_ff, 1'b0);
      kin6_in = fp_mul(cfg.kinetic_k, s5_ff);
      gas7_in = fp_add(e6_ff, kin6_ff, 1'b1);
      p8_in = fp_mul(rg7_ff, gas7_ff);
      if (cfg.eos_isothermal) begin
         pressure9_in = rg8_ff;
         floored9_in = 1'b0;
      end else if (fp_lt(p8_ff, cfg.pressure_floor)) begin
         pressure9_in = cfg.pressure_floor;
         floored9_in = 1'b1;
      end else begin
         pressure9_in = p8_ff;
         floored9_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         last_ff[0] <= in_last;
         for (int i = 1; i < NumStages; i++) last_ff[i] <= last_ff[i-1];
         for (int i = 0; i < NumLanes; i++) begin
            new0_ff[i] <= in_new[i];
            old0_ff[i] <= in_old[i];
            a1_ff[i] <= a1_in[i];
            b1_ff[i] <= b1_in[i];
            new1_ff[i] <= new0_ff[i];
            blend2_ff[i] <= blend2_in[i];
         end
         for (int i = 0; i < 3; i++) sq3_ff[i] <= sq3_in[i];
         rg3_ff <= rg3_in;
         e3_ff <= blend2_ff[LaneEnergy];
         s4_ff <= s4_in;
         sq4_ff <= sq3_ff[2];
         rg4_ff <= rg3_ff;
         e4_ff <= e3_ff;
         s5_ff <= s5_in;
         rg5_ff <= rg4_ff;
         e5_ff <= e4_ff;
         kin6_ff <= kin6_in;
         rg6_ff <= rg5_ff;
         e6_ff <= e5_ff;
         gas7_ff <= gas7_in;
         rg7_ff <= rg6_ff;
         p8_ff <= p8_in;
         rg8_ff <= rg7_ff;
         pressure9_ff <= pressure9_in;
         floored9_ff <= floored9_in;
      end
   end

   assign out_valid = valid_ff[NumStages-1];
   assign out_pressure = pressure9_ff;
   assign out_floored = floored9_ff;
   assign out_last = last_ff[NumStages-1];

endmodule
